[sv/emap_pkg.sv]
`timescale 1ns / 1ps

package emap_pkg;

   // Table geometry
   localparam int MAX_EXONS = 64;
   localparam int IDX_W     = $clog2(MAX_EXONS);
   localparam int CNT_W     = $clog2(MAX_EXONS + 1);

   // Field widths
   localparam int POS_W  = 32;
   localparam int CMD_W  = 2;
   localparam int STAT_W = 3;

   // Commands
   localparam logic [CMD_W-1:0] CMD_CLEAR     = 2'd0;
   localparam logic [CMD_W-1:0] CMD_APPEND    = 2'd1;
   localparam logic [CMD_W-1:0] CMD_TO_CODING = 2'd2;
   localparam logic [CMD_W-1:0] CMD_TO_CONTIG = 2'd3;

   // Result status codes
   localparam logic [STAT_W-1:0] STATUS_OK     = 3'd0;
   localparam logic [STAT_W-1:0] STATUS_MISS   = 3'd1;
   localparam logic [STAT_W-1:0] STATUS_EMPTY  = 3'd2;
   localparam logic [STAT_W-1:0] STATUS_REJECT = 3'd3;
   localparam logic [STAT_W-1:0] STATUS_FULL   = 3'd4;

   // Configuration register indexes (by word address)
   localparam logic REG_STRAND_REVERSE = 1'b0;
   localparam logic REG_CONTIG_BASE    = 1'b1;

   // Controller to datapath
   typedef struct packed {
      logic             capture;   // latch the accepted item
      logic             exec;      // run clear / append / query setup
      logic             rd_en;     // read one table entry
      logic [IDX_W-1:0] rd_step;   // walk step of that read
      logic             out_load;  // load the result register
   } dp_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic             query;     // latched command is a mapping query
      logic [CNT_W-1:0] count;     // entries in the table
   } dp_stat_type;

endpackage

[sv/emap_req_if.sv]
`timescale 1ns / 1ps

interface emap_req_if import emap_pkg::*;;
   logic             valid;
   logic             ready;
   logic [CMD_W-1:0] command;
   logic [POS_W-1:0] interval_begin;
   logic [POS_W-1:0] interval_end;
   logic [POS_W-1:0] query_position;

   modport source (output valid, command, interval_begin, interval_end, query_position,
                   input ready);
   modport sink   (input valid, command, interval_begin, interval_end, query_position,
                   output ready);
endinterface

[sv/emap_rsp_if.sv]
`timescale 1ns / 1ps

interface emap_rsp_if import emap_pkg::*;;
   logic              valid;
   logic              ready;
   logic [STAT_W-1:0] status;
   logic [POS_W-1:0]  mapped_position;
   logic [POS_W-1:0]  total_length;

   modport source (output valid, status, mapped_position, total_length, input ready);
   modport sink   (input valid, status, mapped_position, total_length, output ready);
endinterface

[sv/exon_coordinate_mapper.sv]
`timescale 1ns / 1ps

// Channel   Dir  Handshake               Contents
// req       in   valid/ready             command, interval_begin, interval_end, query_position
// rsp       out  valid/ready             status, mapped_position, total_length
// csr       in   APB write/read          strand_reverse (0x0), contig_base (0x4)
//
// Clear and append pass from accept through the exec and result states to load their
// result; a mapping query walks the exon memory between exec and result, one registered
// read per cycle, then drains the last read. A new item is accepted the cycle after the
// result loads.
// Synchronous active-high reset empties the table; memory contents are not cleared.
// A stalled result holds in the output register while the next item is accepted.

module exon_coordinate_mapper import emap_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   emap_req_if.sink           req,
   emap_rsp_if.source         rsp,
   input  logic               csr_psel,
   input  logic               csr_penable,
   input  logic               csr_pwrite,
   input  logic [2:0]         csr_paddr,
   input  logic [31:0]        csr_pwdata,
   output logic [31:0]        csr_prdata,
   output logic               csr_pready
);

   dp_cmd_type  cmd;
   dp_stat_type stat;

   logic             strand_ff, strand_in;
   logic [POS_W-1:0] base_ff, base_in;
   logic             csr_wr;

   // configuration registers
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_comb begin
      strand_in = strand_ff;
      base_in   = base_ff;
      if (csr_wr) begin
         case (csr_paddr[2])
            REG_STRAND_REVERSE: strand_in = csr_pwdata[0];
            REG_CONTIG_BASE:    base_in   = csr_pwdata;
            default:            strand_in = strand_ff;
         endcase
      end
   end

   assign csr_prdata = (csr_paddr[2] == REG_CONTIG_BASE) ? base_ff : {31'b0, strand_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         strand_ff <= 1'b0;
         base_ff   <= '0;
      end else begin
         strand_ff <= strand_in;
         base_ff   <= base_in;
      end
   end

   emap_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req.ready),
      .rsp_valid (rsp.valid),
      .rsp_ready (rsp.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   emap_dp u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .stat            (stat),
      .command         (req.command),
      .interval_begin  (req.interval_begin),
      .interval_end    (req.interval_end),
      .query_position  (req.query_position),
      .strand_reverse  (strand_ff),
      .contig_base     (base_ff),
      .status          (rsp.status),
      .mapped_position (rsp.mapped_position),
      .total_length    (rsp.total_length)
   );

endmodule

[sv/emap_ctrl.sv]
`timescale 1ns / 1ps

module emap_ctrl import emap_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   input  dp_stat_type stat,
   output dp_cmd_type  cmd
);

   typedef enum logic [4:0] {
      S_IDLE   = 5'b00001,
      S_EXEC   = 5'b00010,
      S_WALK   = 5'b00100,
      S_DRAIN  = 5'b01000,
      S_RESULT = 5'b10000
   } ctrl_state_type;

   ctrl_state_type   state_ff, state_in;
   logic [IDX_W-1:0] step_ff, step_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [IDX_W-1:0] last_step;

   // last walk step is count - 1 (count is nonzero while walking)
   assign last_step = stat.count[IDX_W-1:0] - IDX_W'(1);

   // next state and datapath commands
   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      cmd          = '0;
      cmd.rd_step  = step_ff;
      req_ready    = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = S_EXEC;
            end
         end
         S_EXEC: begin
            cmd.exec = 1'b1;
            step_in  = '0;
            if (stat.query && (stat.count != '0)) begin
               state_in = S_WALK;
            end else begin
               state_in = S_RESULT;
            end
         end
         S_WALK: begin
            cmd.rd_en = 1'b1;
            if (step_ff == last_step) begin
               state_in = S_DRAIN;
            end else begin
               step_in = step_ff + IDX_W'(1);
            end
         end
         S_DRAIN: begin
            state_in = S_RESULT;
         end
         S_RESULT: begin
            // wait for the result register to free up
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // result valid: set on load, cleared when taken
   assign rsp_valid_in = cmd.out_load | (rsp_valid_ff & ~rsp_ready);
   assign rsp_valid    = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

[sv/emap_dp.sv]
`timescale 1ns / 1ps

module emap_dp import emap_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  dp_cmd_type        cmd,
   output dp_stat_type       stat,
   input  logic [CMD_W-1:0]  command,
   input  logic [POS_W-1:0]  interval_begin,
   input  logic [POS_W-1:0]  interval_end,
   input  logic [POS_W-1:0]  query_position,
   input  logic              strand_reverse,
   input  logic [POS_W-1:0]  contig_base,
   output logic [STAT_W-1:0] status,
   output logic [POS_W-1:0]  mapped_position,
   output logic [POS_W-1:0]  total_length
);

   // latched item
   logic [CMD_W-1:0] cmd_ff;
   logic [POS_W-1:0] begin_ff, end_ff, query_ff, contig_ff;

   // table control
   logic [CNT_W-1:0] count_ff, count_in;
   logic [POS_W-1:0] last_begin_ff, last_begin_in;
   logic [POS_W-1:0] total_ff, total_in;

   // exon memory: {begin, end} per entry
   logic [2*POS_W-1:0] exon_mem_ff [MAX_EXONS];
   logic [2*POS_W-1:0] rd_data_ff;
   logic               rd_vld_ff;
   logic               mem_we;
   logic [IDX_W-1:0]   rd_addr;

   // walk accumulators
   logic [POS_W-1:0]  acc_ff, acc_in;
   logic [POS_W-1:0]  run_ff, run_in;
   logic              hit_ff, hit_in;
   logic              walked_ff, walked_in;
   logic [STAT_W-1:0] st_ff, st_in;

   // result register
   logic [STAT_W-1:0] out_status_ff;
   logic [POS_W-1:0]  out_mapped_ff, out_total_ff;

   // walk step datapath
   logic [POS_W-1:0] lo, hi, len, stop, off;

   assign stat.query = (cmd_ff == CMD_TO_CODING) || (cmd_ff == CMD_TO_CONTIG);
   assign stat.count = count_ff;

   // reverse strand walks from the last entry down
   assign rd_addr = strand_reverse ? (count_ff[IDX_W-1:0] - IDX_W'(1) - cmd.rd_step)
                                   : cmd.rd_step;

   assign lo   = rd_data_ff[2*POS_W-1:POS_W];
   assign hi   = rd_data_ff[POS_W-1:0];
   assign len  = hi - lo;
   assign stop = run_ff + len;
   assign off  = query_ff - run_ff;

   // table update, query setup and per-entry walk step
   always_comb begin
      count_in      = count_ff;
      last_begin_in = last_begin_ff;
      total_in      = total_ff;
      acc_in        = acc_ff;
      run_in        = run_ff;
      hit_in        = hit_ff;
      walked_in     = walked_ff;
      st_in         = st_ff;
      mem_we        = 1'b0;

      if (cmd.exec) begin
         acc_in    = '0;
         run_in    = '0;
         hit_in    = 1'b0;
         walked_in = 1'b0;
         st_in     = STATUS_OK;
         case (cmd_ff)
            CMD_CLEAR: begin
               count_in = '0;
               total_in = '0;
            end
            CMD_APPEND: begin
               if (count_ff == CNT_W'(MAX_EXONS)) begin
                  st_in = STATUS_FULL;
               end else if ((end_ff < begin_ff) ||
                            ((count_ff != '0) && (begin_ff <= last_begin_ff))) begin
                  st_in = STATUS_REJECT;
               end else begin
                  mem_we        = 1'b1;
                  count_in      = count_ff + CNT_W'(1);
                  last_begin_in = begin_ff;
                  total_in      = total_ff + (end_ff - begin_ff);
               end
            end
            default: begin
               if (count_ff == '0) begin
                  st_in = STATUS_EMPTY;
               end else begin
                  walked_in = 1'b1;
               end
            end
         endcase
      end else if (rd_vld_ff) begin
         if (cmd_ff == CMD_TO_CODING) begin
            if ((contig_ff >= lo) && (contig_ff < hi)) begin
               acc_in = acc_ff + (strand_reverse ? (hi - contig_ff - POS_W'(1))
                                                 : (contig_ff - lo));
               hit_in = 1'b1;
            end else if (strand_reverse ? (contig_ff < lo) : (contig_ff >= hi)) begin
               acc_in = acc_ff + len;
            end
         end else begin
            // running offset advances by every exon's length
            if ((query_ff >= run_ff) && (query_ff < stop)) begin
               acc_in = strand_reverse ? (hi - POS_W'(1) - off) : (lo + off);
               hit_in = 1'b1;
            end
            run_in = stop;
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         total_ff  <= '0;
         rd_vld_ff <= 1'b0;
      end else begin
         count_ff  <= count_in;
         total_ff  <= total_in;
         rd_vld_ff <= cmd.rd_en;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         cmd_ff    <= command;
         begin_ff  <= interval_begin;
         end_ff    <= interval_end;
         query_ff  <= query_position;
         contig_ff <= query_position + contig_base;
      end
      last_begin_ff <= last_begin_in;
      acc_ff        <= acc_in;
      run_ff        <= run_in;
      hit_ff        <= hit_in;
      walked_ff     <= walked_in;
      st_ff         <= st_in;
      if (cmd.out_load) begin
         out_status_ff <= (walked_ff && !hit_ff) ? STATUS_MISS : st_ff;
         out_mapped_ff <= (walked_ff && hit_ff) ? acc_ff : '0;
         out_total_ff  <= (walked_ff && hit_ff) ? total_ff : '0;
      end
   end

   // memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         exon_mem_ff[count_ff[IDX_W-1:0]] <= {begin_ff, end_ff};
      end
      if (cmd.rd_en) begin
         rd_data_ff <= exon_mem_ff[rd_addr];
      end
   end

   assign status          = out_status_ff;
   assign mapped_position = out_mapped_ff;
   assign total_length    = out_total_ff;

endmodule
